### hw/rtl/ccc_pkg.sv
// Package for the circle pair contact pipeline: widths, sideband structs
// and the saturation helper. No dependencies.
`default_nettype none

package ccc_pkg;

   localparam int COORD_W = 32;                 // coordinate word
   localparam int FRAC_W  = 16;                 // fraction bits
   localparam int RAD_W   = COORD_W - 1;        // radius / margin
   localparam int MAG_W   = COORD_W;            // |delta| after saturated centres
   localparam int SQ_W    = 2 * MAG_W + 1;      // dx^2 + dy^2
   localparam int ROOT_W  = MAG_W + 1;          // floor(sqrt(d2))
   localparam int COMB_W  = RAD_W + 2;          // ra + rb + margin
   localparam int R2_W    = 2 * COMB_W;         // combined radius squared
   localparam int PEN_W   = COMB_W + 1;         // penetration, signed
   localparam int SEP_W   = PEN_W;
   localparam int QUO_W   = FRAC_W + 1;         // normal magnitude
   localparam int NUM_W   = MAG_W + FRAC_W + 1; // divider numerator
   localparam int NRM_W   = FRAC_W + 2;
   localparam int T2_W    = PEN_W + 1;          // 2*ra - pen
   localparam int PROD_W  = NRM_W + T2_W;
   localparam int SAT_W   = PROD_W + 1;

   localparam logic signed [SAT_W-1:0] SAT_HI = {{(SAT_W-COORD_W+1){1'b0}},
                                                 {(COORD_W-1){1'b1}}};
   localparam logic signed [SAT_W-1:0] SAT_LO = ~SAT_HI;
   localparam logic signed [NRM_W-1:0] NRM_ONE = {2'b01, {FRAC_W{1'b0}}};

   typedef struct packed {
      logic                      found;
      logic signed [COORD_W-1:0] cax;
      logic signed [COORD_W-1:0] cay;
      logic [RAD_W-1:0]          ra;
      logic [COMB_W-1:0]         comb;
      logic [MAG_W-1:0]          mx;
      logic [MAG_W-1:0]          my;
      logic                      sx;
      logic                      sy;
   } sq_side_type;

   typedef struct packed {
      logic                      found;
      logic                      zero;
      logic                      sx;
      logic                      sy;
      logic signed [COORD_W-1:0] cax;
      logic signed [COORD_W-1:0] cay;
      logic [RAD_W-1:0]          ra;
      logic signed [PEN_W-1:0]   pen;
   } dv_side_type;

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SAT_W-1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[COORD_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[COORD_W-1:0];
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/ccc_if.sv
// Channel interfaces of the circle pair contact block: request, response
// and register write. Depends on ccc_pkg.
`default_nettype none

interface ccc_req_if;
   import ccc_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] body_a_x;
   logic signed [COORD_W-1:0] body_a_y;
   logic signed [COORD_W-1:0] offset_a_x;
   logic signed [COORD_W-1:0] offset_a_y;
   logic [RAD_W-1:0]          radius_a;
   logic signed [COORD_W-1:0] body_b_x;
   logic signed [COORD_W-1:0] body_b_y;
   logic signed [COORD_W-1:0] offset_b_x;
   logic signed [COORD_W-1:0] offset_b_y;
   logic [RAD_W-1:0]          radius_b;
   modport source (output valid, body_a_x, body_a_y, offset_a_x, offset_a_y, radius_a,
                   body_b_x, body_b_y, offset_b_x, offset_b_y, radius_b, input ready);
   modport sink (input valid, body_a_x, body_a_y, offset_a_x, offset_a_y, radius_a,
                 body_b_x, body_b_y, offset_b_x, offset_b_y, radius_b, output ready);
endinterface

interface ccc_rsp_if;
   import ccc_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      contact_found;
   logic                      touching;
   logic signed [NRM_W-1:0]   normal_x;
   logic signed [NRM_W-1:0]   normal_y;
   logic signed [COORD_W-1:0] point_x;
   logic signed [COORD_W-1:0] point_y;
   logic signed [SEP_W-1:0]   separation;
   modport source (output valid, contact_found, touching, normal_x, normal_y,
                   point_x, point_y, separation, input ready);
   modport sink (input valid, contact_found, touching, normal_x, normal_y,
                 point_x, point_y, separation, output ready);
endinterface

interface ccc_csr_if;
   import ccc_pkg::*;
   logic             valid;
   logic             ready;
   logic [RAD_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/ccc_sqrt.sv
// Pipelined integer square root, one result bit per stage, sideband word
// carried alongside. Depends on ccc_pkg.
`default_nettype none

module ccc_sqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [ccc_pkg::SQ_W-1:0]   in_rad,
   input  ccc_pkg::sq_side_type   in_side,
   output logic                   out_valid,
   output logic [ccc_pkg::ROOT_W-1:0] out_root,
   output ccc_pkg::sq_side_type   out_side
);
   import ccc_pkg::*;

   logic [SQ_W-1:0]   rem_ff  [ROOT_W];
   logic [SQ_W-1:0]   rem_in  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [ROOT_W-1:0] root_in [ROOT_W];
   sq_side_type       side_ff [ROOT_W];
   logic              vld_ff  [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int B = ROOT_W - 1 - k;
      logic [SQ_W-1:0]   rem_p;
      logic [ROOT_W-1:0] root_p;
      logic              vld_p;
      sq_side_type       side_p;
      logic [SQ_W+1:0]   trial;
      logic              take;

      if (k == 0) begin : g_first
         assign rem_p  = in_rad;
         assign root_p = '0;
         assign vld_p  = in_valid;
         assign side_p = in_side;
      end else begin : g_next
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
         assign vld_p  = vld_ff[k-1];
         assign side_p = side_ff[k-1];
      end

      // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B); the two terms never overlap
      assign trial = ((SQ_W+2)'(root_p) << (B + 1)) | ((SQ_W+2)'(1) << (2 * B));
      assign take  = {2'b00, rem_p} >= trial;
      assign rem_in[k]  = take ? rem_p - trial[SQ_W-1:0] : rem_p;
      assign root_in[k] = take ? root_p | (ROOT_W'(1) << B) : root_p;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_p;
         end
         if (en) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            side_ff[k] <= side_p;
         end
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

`default_nettype wire

### hw/rtl/ccc_div.sv
// Pipelined two-lane restoring divider for the normal components, one
// quotient bit per stage, shared divisor. Depends on ccc_pkg.
`default_nettype none

module ccc_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [ccc_pkg::NUM_W-1:0]  in_num_x,
   input  logic [ccc_pkg::NUM_W-1:0]  in_num_y,
   input  logic [ccc_pkg::ROOT_W-1:0] in_den,
   input  ccc_pkg::dv_side_type     in_side,
   output logic                     out_valid,
   output logic [ccc_pkg::QUO_W-1:0]  out_qx,
   output logic [ccc_pkg::QUO_W-1:0]  out_qy,
   output ccc_pkg::dv_side_type     out_side
);
   import ccc_pkg::*;

   logic [NUM_W-1:0]  rx_ff  [QUO_W];
   logic [NUM_W-1:0]  ry_ff  [QUO_W];
   logic [NUM_W-1:0]  rx_in  [QUO_W];
   logic [NUM_W-1:0]  ry_in  [QUO_W];
   logic [QUO_W-1:0]  qx_ff  [QUO_W];
   logic [QUO_W-1:0]  qy_ff  [QUO_W];
   logic [QUO_W-1:0]  qx_in  [QUO_W];
   logic [QUO_W-1:0]  qy_in  [QUO_W];
   logic [ROOT_W-1:0] den_ff [QUO_W];
   dv_side_type       side_ff[QUO_W];
   logic              vld_ff [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      localparam int B = QUO_W - 1 - k;
      logic [NUM_W-1:0]  rx_p, ry_p;
      logic [QUO_W-1:0]  qx_p, qy_p;
      logic [ROOT_W-1:0] den_p;
      logic              vld_p;
      dv_side_type       side_p;
      logic [NUM_W:0]    trial;
      logic              tx, ty;

      if (k == 0) begin : g_first
         assign rx_p   = in_num_x;
         assign ry_p   = in_num_y;
         assign qx_p   = '0;
         assign qy_p   = '0;
         assign den_p  = in_den;
         assign vld_p  = in_valid;
         assign side_p = in_side;
      end else begin : g_next
         assign rx_p   = rx_ff[k-1];
         assign ry_p   = ry_ff[k-1];
         assign qx_p   = qx_ff[k-1];
         assign qy_p   = qy_ff[k-1];
         assign den_p  = den_ff[k-1];
         assign vld_p  = vld_ff[k-1];
         assign side_p = side_ff[k-1];
      end

      assign trial = (NUM_W+1)'(den_p) << B;
      assign tx = {1'b0, rx_p} >= trial;
      assign ty = {1'b0, ry_p} >= trial;
      assign rx_in[k] = tx ? rx_p - trial[NUM_W-1:0] : rx_p;
      assign ry_in[k] = ty ? ry_p - trial[NUM_W-1:0] : ry_p;
      assign qx_in[k] = tx ? qx_p | (QUO_W'(1) << B) : qx_p;
      assign qy_in[k] = ty ? qy_p | (QUO_W'(1) << B) : qy_p;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_p;
         end
         if (en) begin
            rx_ff[k]   <= rx_in[k];
            ry_ff[k]   <= ry_in[k];
            qx_ff[k]   <= qx_in[k];
            qy_ff[k]   <= qy_in[k];
            den_ff[k]  <= den_p;
            side_ff[k] <= side_p;
         end
      end
   end

   assign out_valid = vld_ff[QUO_W-1];
   assign out_qx    = qx_ff[QUO_W-1];
   assign out_qy    = qy_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

`default_nettype wire

### hw/rtl/circle_circle_contact.sv
// Circle pair contact generation, top level. Uses ccc_pkg, ccc_if, ccc_sqrt, ccc_div.
// Pipeline: from an accepted request word to its response word there are
// 4 front stages, 33 root stages, 17 divider stages and 3 back stages.
// Throughput: one word per cycle; the whole pipe advances together and
// holds while the response register waits to be taken.
// Reset: synchronous; clears all valid bits and the margin register to 0.
`default_nettype none

module circle_circle_contact (
   input  logic      clock,
   input  logic      reset,
   ccc_req_if.sink   req_ch,
   ccc_rsp_if.source rsp_ch,
   ccc_csr_if.sink   csr_ch
);
   import ccc_pkg::*;

   logic en;

   // register
   logic [RAD_W-1:0] margin_ff;

   // stage 1: world centres
   logic                      s1_vld_ff;
   logic signed [COORD_W-1:0] s1_cax_ff, s1_cay_ff, s1_cbx_ff, s1_cby_ff;
   logic signed [COORD_W-1:0] s1_cax_in, s1_cay_in, s1_cbx_in, s1_cby_in;
   logic [RAD_W-1:0]          s1_ra_ff;
   logic [COMB_W-1:0]         s1_comb_ff, s1_comb_in;

   // stage 2: deltas
   logic                      s2_vld_ff;
   sq_side_type               s2_side_ff, s2_side_in;
   logic signed [COORD_W:0]   dx, dy;

   // stage 3: squares
   logic                      s3_vld_ff;
   sq_side_type               s3_side_ff;
   logic [2*MAG_W-1:0]        s3_sqx_ff, s3_sqy_ff;
   logic [R2_W-1:0]           s3_r2_ff;

   // stage 4: d2 and range test
   logic                      s4_vld_ff;
   sq_side_type               s4_side_ff, s4_side_in;
   logic [SQ_W-1:0]           s4_d2_ff, s4_d2_in;

   // root and divider
   logic                      rt_vld;
   logic [ROOT_W-1:0]         rt_root;
   sq_side_type               rt_side;
   dv_side_type               dv_side_in, dv_side;
   logic [NUM_W-1:0]          num_x, num_y;
   logic                      dv_vld;
   logic [QUO_W-1:0]          dv_qx, dv_qy;

   // stage N: normal and lever
   logic                      sn_vld_ff;
   logic signed [NRM_W-1:0]   sn_nx_ff, sn_ny_ff, sn_nx_in, sn_ny_in;
   logic signed [T2_W-1:0]    sn_t2_ff, sn_t2_in;
   dv_side_type               sn_side_ff;

   // stage M: products, normals travel alongside
   logic                      sm_vld_ff;
   logic signed [PROD_W-1:0]  sm_px_ff, sm_py_ff;
   logic signed [NRM_W-1:0]   sm_nx_ff, sm_ny_ff;
   dv_side_type               sm_side_ff;

   // response register
   logic                      rsp_vld_ff;
   logic                      found_ff, touching_ff;
   logic signed [NRM_W-1:0]   normal_x_ff, normal_y_ff;
   logic signed [COORD_W-1:0] point_x_ff, point_y_ff, point_x_in, point_y_in;
   logic signed [SEP_W-1:0]   separation_ff;

   assign en            = !rsp_vld_ff || rsp_ch.ready;
   assign req_ch.ready  = en;
   assign csr_ch.ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= '0;
      end else if (csr_ch.valid) begin
         margin_ff <= csr_ch.data;
      end
   end

   // ---- stage 1
   assign s1_cax_in = sat_coord(SAT_W'(req_ch.body_a_x) + SAT_W'(req_ch.offset_a_x));
   assign s1_cay_in = sat_coord(SAT_W'(req_ch.body_a_y) + SAT_W'(req_ch.offset_a_y));
   assign s1_cbx_in = sat_coord(SAT_W'(req_ch.body_b_x) + SAT_W'(req_ch.offset_b_x));
   assign s1_cby_in = sat_coord(SAT_W'(req_ch.body_b_y) + SAT_W'(req_ch.offset_b_y));
   assign s1_comb_in = COMB_W'(req_ch.radius_a) + COMB_W'(req_ch.radius_b)
                     + COMB_W'(margin_ff);

   // ---- stage 2
   assign dx = (COORD_W+1)'(s1_cbx_ff) - (COORD_W+1)'(s1_cax_ff);
   assign dy = (COORD_W+1)'(s1_cby_ff) - (COORD_W+1)'(s1_cay_ff);

   always_comb begin
      s2_side_in       = '0;
      s2_side_in.cax   = s1_cax_ff;
      s2_side_in.cay   = s1_cay_ff;
      s2_side_in.ra    = s1_ra_ff;
      s2_side_in.comb  = s1_comb_ff;
      s2_side_in.sx    = dx[COORD_W];
      s2_side_in.sy    = dy[COORD_W];
      s2_side_in.mx    = dx[COORD_W] ? MAG_W'(-dx) : MAG_W'(dx);
      s2_side_in.my    = dy[COORD_W] ? MAG_W'(-dy) : MAG_W'(dy);
   end

   // ---- stage 4
   assign s4_d2_in = SQ_W'(s3_sqx_ff) + SQ_W'(s3_sqy_ff);
   always_comb begin
      s4_side_in       = s3_side_ff;
      s4_side_in.found = !(R2_W'(s4_d2_in) > s3_r2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_ch.valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
      if (en) begin
         s1_cax_ff  <= s1_cax_in;
         s1_cay_ff  <= s1_cay_in;
         s1_cbx_ff  <= s1_cbx_in;
         s1_cby_ff  <= s1_cby_in;
         s1_ra_ff   <= req_ch.radius_a;
         s1_comb_ff <= s1_comb_in;
         s2_side_ff <= s2_side_in;
         s3_side_ff <= s2_side_ff;
         s3_sqx_ff  <= (2*MAG_W)'(s2_side_ff.mx) * (2*MAG_W)'(s2_side_ff.mx);
         s3_sqy_ff  <= (2*MAG_W)'(s2_side_ff.my) * (2*MAG_W)'(s2_side_ff.my);
         s3_r2_ff   <= R2_W'(s2_side_ff.comb) * R2_W'(s2_side_ff.comb);
         s4_side_ff <= s4_side_in;
         s4_d2_ff   <= s4_d2_in;
      end
   end

   ccc_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s4_vld_ff),
      .in_rad    (s4_d2_ff),
      .in_side   (s4_side_ff),
      .out_valid (rt_vld),
      .out_root  (rt_root),
      .out_side  (rt_side)
   );

   // numerator carries half the divisor for round-to-nearest
   assign num_x = NUM_W'({rt_side.mx, {FRAC_W{1'b0}}}) + NUM_W'(rt_root >> 1);
   assign num_y = NUM_W'({rt_side.my, {FRAC_W{1'b0}}}) + NUM_W'(rt_root >> 1);

   always_comb begin
      dv_side_in.found = rt_side.found;
      dv_side_in.zero  = rt_root == '0;
      dv_side_in.sx    = rt_side.sx;
      dv_side_in.sy    = rt_side.sy;
      dv_side_in.cax   = rt_side.cax;
      dv_side_in.cay   = rt_side.cay;
      dv_side_in.ra    = rt_side.ra;
      dv_side_in.pen   = $signed(PEN_W'(rt_side.comb)) - $signed(PEN_W'(rt_root));
   end

   ccc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rt_vld),
      .in_num_x  (num_x),
      .in_num_y  (num_y),
      .in_den    (rt_root),
      .in_side   (dv_side_in),
      .out_valid (dv_vld),
      .out_qx    (dv_qx),
      .out_qy    (dv_qy),
      .out_side  (dv_side)
   );

   // ---- stage N: coincident centres give (1,0)
   always_comb begin
      if (dv_side.zero) begin
         sn_nx_in = NRM_ONE;
         sn_ny_in = '0;
      end else begin
         sn_nx_in = dv_side.sx ? -$signed(NRM_W'(dv_qx)) : $signed(NRM_W'(dv_qx));
         sn_ny_in = dv_side.sy ? -$signed(NRM_W'(dv_qy)) : $signed(NRM_W'(dv_qy));
      end
   end
   assign sn_t2_in = $signed(T2_W'({dv_side.ra, 1'b0})) - T2_W'(dv_side.pen);

   // ---- response stage: product / 2^(FRAC+1), rounded away from zero on ties
   function automatic logic signed [SAT_W-1:0] rnd_shr(input logic signed [PROD_W-1:0] p);
      logic [PROD_W-1:0] m;
      logic [PROD_W-1:0] q;
      m = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
      q = (m + (PROD_W'(1) << FRAC_W)) >> (FRAC_W + 1);
      return p[PROD_W-1] ? -$signed(SAT_W'(q)) : $signed(SAT_W'(q));
   endfunction

   assign point_x_in = sat_coord(SAT_W'(sm_side_ff.cax) + rnd_shr(sm_px_ff));
   assign point_y_in = sat_coord(SAT_W'(sm_side_ff.cay) + rnd_shr(sm_py_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         sn_vld_ff  <= 1'b0;
         sm_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         sn_vld_ff  <= dv_vld;
         sm_vld_ff  <= sn_vld_ff;
         rsp_vld_ff <= sm_vld_ff;
      end
      if (en) begin
         sn_nx_ff   <= sn_nx_in;
         sn_ny_ff   <= sn_ny_in;
         sn_t2_ff   <= sn_t2_in;
         sn_side_ff <= dv_side;
         sm_px_ff   <= PROD_W'(sn_nx_ff) * PROD_W'(sn_t2_ff);
         sm_py_ff   <= PROD_W'(sn_ny_ff) * PROD_W'(sn_t2_ff);
         sm_nx_ff   <= sn_nx_ff;
         sm_ny_ff   <= sn_ny_ff;
         sm_side_ff <= sn_side_ff;
         if (sm_side_ff.found) begin
            found_ff      <= 1'b1;
            touching_ff   <= sm_side_ff.pen > 0;
            normal_x_ff   <= sm_nx_ff;
            normal_y_ff   <= sm_ny_ff;
            point_x_ff    <= point_x_in;
            point_y_ff    <= point_y_in;
            separation_ff <= -sm_side_ff.pen;
         end else begin
            found_ff      <= 1'b0;
            touching_ff   <= 1'b0;
            normal_x_ff   <= '0;
            normal_y_ff   <= '0;
            point_x_ff    <= '0;
            point_y_ff    <= '0;
            separation_ff <= '0;
         end
      end
   end

   assign rsp_ch.valid         = rsp_vld_ff;
   assign rsp_ch.contact_found = found_ff;
   assign rsp_ch.touching      = touching_ff;
   assign rsp_ch.normal_x      = normal_x_ff;
   assign rsp_ch.normal_y      = normal_y_ff;
   assign rsp_ch.point_x       = point_x_ff;
   assign rsp_ch.point_y       = point_y_ff;
   assign rsp_ch.separation    = separation_ff;

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !found_ff |-> !touching_ff && normal_x_ff == '0 && normal_y_ff == '0
         && point_x_ff == '0 && point_y_ff == '0 && separation_ff == '0)
      else $error("miss word carries nonzero fields");

   a_sep_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && found_ff |-> separation_ff[SEP_W-1] || separation_ff == '0)
      else $error("positive separation on a contact");

   a_touch: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && touching_ff |-> found_ff && separation_ff[SEP_W-1])
      else $error("touching without penetration");

   a_normal: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && found_ff |-> normal_x_ff <= NRM_ONE && normal_x_ff >= -NRM_ONE
         && normal_y_ff <= NRM_ONE && normal_y_ff >= -NRM_ONE)
      else $error("normal component out of unit range");

   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_ch.ready |-> !req_ch.ready)
      else $error("request taken while pipe is held");

endmodule

`default_nettype wire

### verif/circle_circle_contact_tb.sv
// Testbench for circle_circle_contact: drives circle pairs and margin writes,
// predicts each contact word and checks it. Depends on ccc_pkg and ccc_if.
`default_nettype none

module circle_circle_contact_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ccc_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 70;

   typedef struct {
      logic signed [COORD_W-1:0] bax, bay, oax, oay, bbx, bby, obx, oby;
      logic [RAD_W-1:0]          ra, rb;
   } pair_type;

   typedef struct {
      logic                      found;
      logic                      touch;
      logic signed [NRM_W-1:0]   nx, ny;
      logic signed [COORD_W-1:0] px, py;
      logic signed [SEP_W-1:0]   sep;
   } contact_type;

   logic clock;
   logic reset;

   ccc_req_if req_ch ();
   ccc_rsp_if rsp_ch ();
   ccc_csr_if csr_ch ();

   circle_circle_contact uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   contact_type      expected_contacts[$];
   logic [RAD_W-1:0] margin_model;
   int               mismatches;
   int               pairs_sent;
   int               contacts_seen;
   int               found_seen;
   int               margin_writes;
   int               idle_count = 0;
   bit               no_gaps;
   int               rsp_stall = 0;
   int               rsp_handled = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------- prediction ----------------
   function automatic longint clamp_coord(longint v);
      longint hi, lo;
      hi = (longint'(1) <<< (COORD_W - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic longint round_div(longint num, longint den);
      longint m, q;
      m = (num < 0) ? -num : num;
      q = (m + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic longint round_shr(longint v, int sh);
      longint m, q;
      m = (v < 0) ? -v : v;
      q = (m + (longint'(1) <<< (sh - 1))) >>> sh;
      return (v < 0) ? -q : q;
   endfunction

   function automatic contact_type predict_contact(pair_type p, logic [RAD_W-1:0] margin);
      contact_type c;
      longint      cax, cay, cbx, cby, dx, dy, mx, my, comb, distance, nx, ny, pen, t2;
      logic [67:0] ux, uy, uc, d2, r2, root, trial;
      cax = clamp_coord(longint'(p.bax) + longint'(p.oax));
      cay = clamp_coord(longint'(p.bay) + longint'(p.oay));
      cbx = clamp_coord(longint'(p.bbx) + longint'(p.obx));
      cby = clamp_coord(longint'(p.bby) + longint'(p.oby));
      dx = cbx - cax;
      dy = cby - cay;
      mx = (dx < 0) ? -dx : dx;
      my = (dy < 0) ? -dy : dy;
      comb = longint'(p.ra) + longint'(p.rb) + longint'(margin);
      ux = 68'(mx);
      uy = 68'(my);
      uc = 68'(comb);
      d2 = ux * ux + uy * uy;
      r2 = uc * uc;
      c = '{default: '0};
      if (d2 > r2) return c;
      root = '0;
      for (int b = 33; b >= 0; b--) begin
         trial = root | (68'd1 << b);
         if (trial * trial <= d2) root = trial;
      end
      distance = longint'(root);
      if (distance == 0) begin
         nx = longint'(1) <<< FRAC_W;
         ny = 0;
      end else begin
         nx = round_div((dx < 0) ? -(mx <<< FRAC_W) : (mx <<< FRAC_W), distance);
         ny = round_div((dy < 0) ? -(my <<< FRAC_W) : (my <<< FRAC_W), distance);
      end
      pen = comb - distance;
      t2  = 2 * longint'(p.ra) - pen;
      c.found = 1'b1;
      c.touch = (pen > 0);
      c.nx    = nx[NRM_W-1:0];
      c.ny    = ny[NRM_W-1:0];
      c.px    = COORD_W'(clamp_coord(cax + round_shr(nx * t2, FRAC_W + 1)));
      c.py    = COORD_W'(clamp_coord(cay + round_shr(ny * t2, FRAC_W + 1)));
      c.sep   = SEP_W'(-pen);
      return c;
   endfunction

   // ---------------- driving ----------------
   task automatic send_pair(pair_type p);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.body_a_x   = p.bax;
      req_ch.body_a_y   = p.bay;
      req_ch.offset_a_x = p.oax;
      req_ch.offset_a_y = p.oay;
      req_ch.radius_a   = p.ra;
      req_ch.body_b_x   = p.bbx;
      req_ch.body_b_y   = p.bby;
      req_ch.offset_b_x = p.obx;
      req_ch.offset_b_y = p.oby;
      req_ch.radius_b   = p.rb;
      req_ch.valid      = 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_contacts.insert(expected_contacts.size(), predict_contact(p, margin_model));
      pairs_sent++;
      @(negedge clock);
   endtask

   task automatic drain_pipe();
      req_ch.valid = 1'b0;
      while (expected_contacts.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_margin(logic [RAD_W-1:0] value);
      drain_pipe();
      csr_ch.data  = value;
      csr_ch.valid = 1'b1;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      margin_model = value;
      margin_writes++;
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   function automatic pair_type make_pair(longint ax, longint ay, longint ra,
                                          longint bx, longint by, longint rb);
      pair_type p;
      p.bax = COORD_W'(ax);  p.bay = COORD_W'(ay);  p.oax = '0; p.oay = '0;
      p.ra  = RAD_W'(ra);
      p.bbx = COORD_W'(bx);  p.bby = COORD_W'(by);  p.obx = '0; p.oby = '0;
      p.rb  = RAD_W'(rb);
      return p;
   endfunction

   function automatic pair_type random_pair();
      pair_type p;
      int       mode;
      longint   span;
      mode = $urandom_range(0, 9);
      p.bax = $urandom; p.bay = $urandom; p.oax = $urandom; p.oay = $urandom;
      p.bbx = $urandom; p.bby = $urandom; p.obx = $urandom; p.oby = $urandom;
      p.ra  = RAD_W'($urandom >> 1);
      p.rb  = RAD_W'($urandom >> 1);
      if (mode <= 5) begin
         // nearby circles of comparable size around an arbitrary origin
         span  = longint'(1) <<< $urandom_range(4, 24);
         p.oax = COORD_W'($signed($urandom_range(0, 2 * span)) - span);
         p.oay = COORD_W'($signed($urandom_range(0, 2 * span)) - span);
         p.bbx = COORD_W'(p.bax + $signed($urandom_range(0, 2 * span)) - span);
         p.bby = COORD_W'(p.bay + $signed($urandom_range(0, 2 * span)) - span);
         p.obx = COORD_W'($signed($urandom_range(0, 2 * span)) - span);
         p.oby = COORD_W'($signed($urandom_range(0, 2 * span)) - span);
         p.ra  = RAD_W'($urandom_range(0, 2 * span));
         p.rb  = RAD_W'($urandom_range(0, 2 * span));
      end else if (mode == 7) begin
         // bodies at the edge of the range, offsets pushing past it
         p.bax = $urandom_range(0, 1) ? 32'h7fff_ff00 : 32'h8000_0100;
         p.bbx = $urandom_range(0, 1) ? 32'h7fff_ff00 : 32'h8000_0100;
         p.oax = $signed($urandom_range(0, 1024)) - 512;
         p.obx = $signed($urandom_range(0, 1024)) - 512;
      end else if (mode == 8) begin
         // coincident or nearly coincident centres
         p.bbx = p.bax + $signed($urandom_range(0, 2)) - 1;
         p.bby = p.bay + $signed($urandom_range(0, 2)) - 1;
         p.obx = p.oax;
         p.oby = p.oay;
         p.ra  = RAD_W'($urandom_range(0, 8));
         p.rb  = RAD_W'($urandom_range(0, 8));
      end
      return p;
   endfunction

   // ---------------- tests ----------------
   task automatic test_directed();
      pair_type p;
      send_pair(make_pair(0, 0, 0, 0, 0, 0));                         // coincident, zero radii
      send_pair(make_pair(100, 200, 65536, 100, 200, 65536));         // coincident overlap
      send_pair(make_pair(0, 0, 65536, 131072, 0, 65536));            // exactly touching
      send_pair(make_pair(0, 0, 65536, 131073, 0, 65536));            // just apart
      send_pair(make_pair(0, 0, 65536, 0, -98304, 65536));            // overlap on y
      send_pair(make_pair(0, 0, 100000, 65536, 65536, 100000));       // diagonal
      send_pair(make_pair(0, 0, 1, 1, 1, 1));
      send_pair(make_pair(-5, 7, 3, 5, -7, 10));
      send_pair(make_pair(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                          32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
      send_pair(make_pair(32'h7fff_ffff, 32'h8000_0000, 0,
                          32'h8000_0000, 32'h7fff_ffff, 0));
      send_pair(make_pair(0, 0, 32'h7fff_ffff, 0, 0, 32'h7fff_ffff));
      // centre overflow on both axes, positive and negative
      p = make_pair(32'h7fff_ffff, 32'h7fff_ffff, 1000, 32'h8000_0000, 32'h8000_0000, 1000);
      p.oax = 32'h7fff_ffff; p.oay = 32'h7fff_ffff;
      p.obx = 32'h8000_0000; p.oby = 32'h8000_0000;
      send_pair(p);
      p.bbx = p.bax; p.bby = p.bay; p.obx = p.oax; p.oby = p.oay;
      send_pair(p);
      p = make_pair(32'h8000_0000, 0, 32'h7fff_ffff, 32'h8000_0000, 10, 32'h7fff_ffff);
      p.oax = 32'h8000_0000; p.obx = 32'hffff_ffff;
      send_pair(p);
      // contact point pushed beyond the range by a huge radius
      send_pair(make_pair(32'h7fff_0000, 0, 32'h7fff_ffff, 32'h7fff_0100, 0, 0));
      send_pair(make_pair(32'h8000_1000, 0, 32'h7fff_ffff, 32'h8000_0000, 0, 0));
   endtask

   task automatic test_random(int count, bit quiet);
      no_gaps = quiet;
      repeat (count) send_pair(random_pair());
      no_gaps = 1'b0;
   endtask

   task automatic test_margins();
      write_margin('0);
      test_directed();
      test_random(200, 1'b0);
      write_margin({RAD_W{1'b1}});
      test_directed();
      test_random(150, 1'b0);
      write_margin(31'd65536);
      test_random(200, 1'b1);
      write_margin(RAD_W'($urandom >> 1));
      test_random(150, 1'b0);
      write_margin(RAD_W'($urandom_range(0, 1 << 20)));
      test_random(250, 1'b0);
      drain_pipe();
   endtask

   // ---------------- checking ----------------
   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch on contact word %0d: %s got %0d, want %0d",
               contacts_seen, field, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      contact_type w;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_contacts.size() == 0) begin
            $display("contact word %0d arrived with nothing expected", contacts_seen);
            mismatches++;
         end else begin
            w = expected_contacts.pop_front();
            if (rsp_ch.contact_found !== w.found)
               report_mismatch("contact_found", rsp_ch.contact_found, w.found);
            if (rsp_ch.touching !== w.touch)
               report_mismatch("touching", rsp_ch.touching, w.touch);
            if (rsp_ch.normal_x !== w.nx) report_mismatch("normal_x", rsp_ch.normal_x, w.nx);
            if (rsp_ch.normal_y !== w.ny) report_mismatch("normal_y", rsp_ch.normal_y, w.ny);
            if (rsp_ch.point_x !== w.px) report_mismatch("point_x", rsp_ch.point_x, w.px);
            if (rsp_ch.point_y !== w.py) report_mismatch("point_y", rsp_ch.point_y, w.py);
            if (rsp_ch.separation !== w.sep)
               report_mismatch("separation", rsp_ch.separation, w.sep);
            if (w.found) found_seen++;
         end
         contacts_seen++;
      end
   end

   // response back-pressure, drawn per word taken
   always @(negedge clock) begin
      if (contacts_seen != rsp_handled) begin
         rsp_handled = contacts_seen;
         rsp_stall   = no_gaps ? 0 : $urandom_range(0, 9);
      end
      if (rsp_stall > 0) begin
         rsp_ch.ready = 1'b0;
         rsp_stall = rsp_stall - 1;
      end else begin
         rsp_ch.ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         idle_count <= 0;
      end else if (idle_count >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0; req_ch.body_a_x = '0; req_ch.body_a_y = '0;
      req_ch.offset_a_x = '0; req_ch.offset_a_y = '0; req_ch.radius_a = '0;
      req_ch.body_b_x = '0; req_ch.body_b_y = '0; req_ch.offset_b_x = '0;
      req_ch.offset_b_y = '0; req_ch.radius_b = '0;
      csr_ch.valid = 1'b0;
      csr_ch.data  = '0;
      margin_model = '0;
      mismatches = 0; pairs_sent = 0; contacts_seen = 0; found_seen = 0;
      margin_writes = 0; no_gaps = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_margins();
      if (expected_contacts.size() != 0) begin
         $display("%0d contact words never arrived", expected_contacts.size());
         mismatches++;
      end
      $display("covered %0d circle pairs, %0d contact words (%0d with contact), %0d margin writes",
               pairs_sent, contacts_seen, found_seen, margin_writes);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
